[rtl/wrg_pkg.sv]
// Shared constants and codes for the wave ripple grid block.
`default_nettype none
package wrg_pkg;

  // Default grid limits and height width
  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int DEF_HEIGHT_BITS = 16;

  // Stream word layout
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_DAMPING  = 16'd64881;
  localparam logic [15:0] RST_SPEED    = 16'd2048;
  localparam logic [15:0] RST_INV_CELL = 16'd1024;
  localparam logic [1:0]  RST_BOUNDARY = 2'd0;
  localparam logic [6:0]  RST_WIDTH    = 7'd64;
  localparam logic [6:0]  RST_HEIGHT   = 7'd64;

  // Opcodes
  localparam logic [1:0] OP_STEP   = 2'd0;
  localparam logic [1:0] OP_SPLASH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Boundary modes; any other code behaves as absorb
  localparam logic [1:0] BND_ABSORB = 2'd0;
  localparam logic [1:0] BND_CLAMP  = 2'd1;
  localparam logic [1:0] BND_WRAP   = 2'd2;

  // Status codes
  localparam logic STAT_DONE    = 1'b0;
  localparam logic STAT_OUTSIDE = 1'b1;

  // Coefficient limit: k saturates at one half in Q0.16
  localparam int K_LIMIT = 32768;

endpackage
`default_nettype wire

[rtl/wave_ripple_grid_step.sv]
// Top level: wave grid sequencer with two height banks and a shared multiplier.
//
//  channel | ports                     | word contents (lsb first)
//  --------+---------------------------+------------------------------------------------
//  in      | in_tvalid/in_tready       | tuser: opcode; tdata: time_step, world_x,
//          |                           |        world_y, force_req
//  out     | out_tvalid/out_tready     | tuser: status; tdata: height
//  cfg     | cfg_wr_en/cfg_index/wdata | one register write per cycle, no read-back
//
// A step first forms k and k*k in states K0 to K3 after the accept; then each cell
// issues five reads of the current bank through its single port, then two
// passes through the shared multiplier and one write, and ST_DONE loads the output.
// Splash and read pass ST_CX, ST_CY and ST_CC, then ST_PA and ST_PB only if the
// cell falls inside the grid; clear zeroes one entry per cycle on each bank over all
// MAX_WIDTH*MAX_HEIGHT entries. After reset the same clearing pass runs with
// in_tready low. A finished word waits in the output register while the next
// word is accepted; the sequencer stalls only if that register is still full.
`default_nettype none
module wave_ripple_grid_step #(
  parameter int MAX_WIDTH   = wrg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = wrg_pkg::DEF_MAX_HEIGHT,
  parameter int HEIGHT_BITS = wrg_pkg::DEF_HEIGHT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // time_step[15:0], world_x[31:16], world_y[47:32], force_req[63:48]
  input  wire logic [wrg_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode[1:0]
  input  wire logic [wrg_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // height[15:0]
  output logic      [wrg_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[0]
  output logic      [wrg_pkg::OUT_USER_W-1:0]   out_tuser,
  input  wire logic                             cfg_wr_en,
  input  wire logic [wrg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wrg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int HB    = HEIGHT_BITS;
  localparam int MA    = (HB + 3 > 33) ? HB + 3 : 33;
  localparam int MB    = 18;
  localparam int PW    = MA + MB;
  localparam logic signed [PW-1:0] HMAX_W = PW'((64'sd1 <<< (HB - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] HMIN_W = -HMAX_W - PW'(1);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_K0, ST_K1, ST_K2, ST_K3, ST_RD, ST_LAST, ST_LAP,
    ST_SUM, ST_WR, ST_CX, ST_CY, ST_CC, ST_PA, ST_PB, ST_DONE
  } state_t;

  typedef enum logic [2:0] {PH_C, PH_L, PH_R, PH_U, PH_D} ph_t;

  function automatic logic [HB-1:0] sat_h(input logic signed [PW-1:0] v);
    logic [HB-1:0] r;
    if (v > HMAX_W) begin
      r = HMAX_W[HB-1:0];
    end else if (v < HMIN_W) begin
      r = HMIN_W[HB-1:0];
    end else begin
      r = v[HB-1:0];
    end
    return r;
  endfunction

  state_t state_r;
  ph_t    ph_r;

  // Configuration registers
  logic [15:0] damping_r, speed_r, inv_r;
  logic [1:0]  mode_r;
  logic [6:0]  gw_r, gh_r;

  // Item registers
  logic [1:0]        op_r;
  logic [15:0]       dt_r;
  logic signed [15:0] wx_r, wy_r, force_r;

  // Sequencer state
  logic          bank_sel_r, clr_rsp_r;
  logic [AW-1:0] clr_r;
  logic [XW-1:0] x_r, cx_r;
  logic [YW-1:0] y_r, cy_r;
  logic          inx_r;
  logic [15:0]   k2_r;
  logic          pend_r, cap_c_r, nv_r;
  logic signed [HB-1:0] c_r, old_r;
  logic signed [HB+1:0] nsum_r;
  logic [15:0]   res_h_r;
  logic          res_s_r;
  logic          out_tvalid_r;
  logic [15:0]   out_data_r;
  logic          out_user_r;

  // Effective grid size
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;

  always_comb begin
    eff_w = (32'(gw_r) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(gw_r);
    eff_h = (32'(gh_r) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(gh_r);
    wm1   = XW'(eff_w - 1'b1);
    hm1   = YW'(eff_h - 1'b1);
  end

  // Neighbor coordinates for the current read phase
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic          nvalid;

  always_comb begin
    col    = x_r;
    row    = y_r;
    nvalid = 1'b1;
    unique case (ph_r)
      PH_C: ;
      PH_L: begin
        if (x_r == '0) begin
          if (mode_r == wrg_pkg::BND_CLAMP) col = '0;
          else if (mode_r == wrg_pkg::BND_WRAP) col = wm1;
          else nvalid = 1'b0;
        end else begin
          col = x_r - 1'b1;
        end
      end
      PH_R: begin
        if (x_r == wm1) begin
          if (mode_r == wrg_pkg::BND_CLAMP) col = wm1;
          else if (mode_r == wrg_pkg::BND_WRAP) col = '0;
          else nvalid = 1'b0;
        end else begin
          col = x_r + 1'b1;
        end
      end
      PH_U: begin
        if (y_r == '0) begin
          if (mode_r == wrg_pkg::BND_CLAMP) row = '0;
          else if (mode_r == wrg_pkg::BND_WRAP) row = hm1;
          else nvalid = 1'b0;
        end else begin
          row = y_r - 1'b1;
        end
      end
      PH_D: begin
        if (y_r == hm1) begin
          if (mode_r == wrg_pkg::BND_CLAMP) row = hm1;
          else if (mode_r == wrg_pkg::BND_WRAP) row = '0;
          else nvalid = 1'b0;
        end else begin
          row = y_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Bank address: sweep counter, splash or read cell, or stencil cell
  logic [AW-1:0] addr;

  always_comb begin
    priority if (state_r == ST_CLR) begin
      addr = clr_r;
    end else if (state_r == ST_PA || state_r == ST_PB) begin
      addr = AW'(AW'(cy_r) * AW'(eff_w) + AW'(cx_r));
    end else begin
      addr = AW'(AW'(row) * AW'(eff_w) + AW'(col));
    end
  end

  // Height banks
  logic          we0, we1;
  logic [HB-1:0] wd0, wd1, rd0, rd1;
  logic signed [HB-1:0] cur_s, old_s, rd0_s, rd1_s;

  wrg_ram #(.DEPTH(CELLS), .DW(HB)) u_bank0 (
    .clk(clk), .we(we0), .addr(addr), .wdata(wd0), .rdata_r(rd0)
  );

  wrg_ram #(.DEPTH(CELLS), .DW(HB)) u_bank1 (
    .clk(clk), .we(we1), .addr(addr), .wdata(wd1), .rdata_r(rd1)
  );

  assign rd0_s = rd0;
  assign rd1_s = rd1;
  assign cur_s = bank_sel_r ? rd1_s : rd0_s;
  assign old_s = bank_sel_r ? rd0_s : rd1_s;

  // Shared multiplier
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] p_r, p_sh;

  wrg_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r)
  );

  assign p_sh = p_r >>> 16;

  // Arithmetic around the multiplier
  logic [15:0]          k_val;
  logic signed [MA-1:0] lap, s_val;
  logic [HB-1:0]        new_h, spl0, spl1;
  logic [PW-1:0]        mag;
  logic [16:0]          cm;
  logic                 cneg, in_x, in_y;
  logic signed [PW-1:0] rext;

  always_comb begin
    k_val = (p_r[PW-1:16] > (PW-16)'(wrg_pkg::K_LIMIT)) ? 16'(wrg_pkg::K_LIMIT)
                                                         : p_r[31:16];
    lap   = MA'(nsum_r) - (MA'(c_r) <<< 2);
    s_val = (MA'(c_r) <<< 1) - MA'(old_r) + MA'(p_sh);
    new_h = sat_h(p_sh);
    spl0  = sat_h(PW'(rd0_s) + PW'(force_r));
    spl1  = sat_h(PW'(rd1_s) + PW'(force_r));
    cneg  = p_r[PW-1];
    mag   = cneg ? PW'(-p_r) : PW'(p_r);
    cm    = mag[32:16];
    // A negative product is inside only when it truncates to cell zero
    in_x  = (cneg ? (cm == '0) : 1'b1) && (32'(cm) < 32'(eff_w));
    in_y  = (cneg ? (cm == '0) : 1'b1) && (32'(cm) < 32'(eff_h));
    rext  = PW'(cur_s);
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_K0:  begin mul_a = MA'(speed_r);    mul_b = MB'(dt_r);    end
      ST_K1:  begin mul_a = MA'(p_r[31:0]);  mul_b = MB'(inv_r);   end
      ST_K2:  begin mul_a = MA'(k_val);      mul_b = MB'(k_val);   end
      ST_LAP: begin mul_a = lap;             mul_b = MB'(k2_r);    end
      ST_SUM: begin mul_a = s_val;           mul_b = MB'(damping_r); end
      ST_CX:  begin mul_a = MA'(wx_r);       mul_b = MB'(inv_r);   end
      ST_CY:  begin mul_a = MA'(wy_r);       mul_b = MB'(inv_r);   end
      default: ;
    endcase
  end

  // Bank write select
  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wd0 = new_h;
    wd1 = new_h;
    unique case (state_r)
      ST_CLR: begin
        we0 = 1'b1;
        we1 = 1'b1;
        wd0 = '0;
        wd1 = '0;
      end
      ST_WR: begin
        we0 = bank_sel_r;
        we1 = !bank_sel_r;
      end
      ST_PB: begin
        we0 = (op_r == wrg_pkg::OP_SPLASH);
        we1 = (op_r == wrg_pkg::OP_SPLASH);
        wd0 = spl0;
        wd1 = spl1;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      ph_r         <= PH_C;
      clr_r        <= '0;
      clr_rsp_r    <= 1'b0;
      bank_sel_r   <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      damping_r    <= wrg_pkg::RST_DAMPING;
      speed_r      <= wrg_pkg::RST_SPEED;
      inv_r        <= wrg_pkg::RST_INV_CELL;
      mode_r       <= wrg_pkg::RST_BOUNDARY;
      gw_r         <= wrg_pkg::RST_WIDTH;
      gh_r         <= wrg_pkg::RST_HEIGHT;
    end else begin
      // Take register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          wrg_pkg::REG_DAMPING:  damping_r <= cfg_wdata;
          wrg_pkg::REG_SPEED:    speed_r   <= cfg_wdata;
          wrg_pkg::REG_INV_CELL: inv_r     <= cfg_wdata;
          wrg_pkg::REG_BOUNDARY: mode_r    <= cfg_wdata[1:0];
          wrg_pkg::REG_WIDTH:    gw_r      <= cfg_wdata[6:0];
          wrg_pkg::REG_HEIGHT:   gh_r      <= cfg_wdata[6:0];
          default: ;
        endcase
      end

      // Load a finished word, drop the output word once taken
      if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      // Collect each stencil read in the cycle after it is issued
      pend_r  <= (state_r == ST_RD);
      cap_c_r <= (ph_r == PH_C);
      nv_r    <= nvalid;
      if (pend_r) begin
        if (cap_c_r) begin
          c_r    <= cur_s;
          old_r  <= old_s;
          nsum_r <= '0;
        end else if (nv_r) begin
          nsum_r <= nsum_r + (HB+2)'(cur_s);
        end
      end

      unique case (state_r)
        ST_CLR: begin
          if (clr_r == AW'(CELLS - 1)) begin
            clr_r   <= '0;
            state_r <= clr_rsp_r ? ST_DONE : ST_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r      <= in_tuser;
            dt_r      <= in_tdata[15:0];
            wx_r      <= in_tdata[31:16];
            wy_r      <= in_tdata[47:32];
            force_r   <= in_tdata[63:48];
            res_h_r   <= '0;
            res_s_r   <= wrg_pkg::STAT_DONE;
            x_r       <= '0;
            y_r       <= '0;
            ph_r      <= PH_C;
            clr_rsp_r <= 1'b1;
            unique case (in_tuser)
              wrg_pkg::OP_STEP:
                state_r <= (eff_w == '0 || eff_h == '0) ? ST_DONE : ST_K0;
              wrg_pkg::OP_CLEAR: state_r <= ST_CLR;
              default:           state_r <= ST_CX;
            endcase
          end
        end
        ST_K0: state_r <= ST_K1;
        ST_K1: state_r <= ST_K2;
        ST_K2: state_r <= ST_K3;
        ST_K3: begin
          k2_r    <= p_r[31:16];
          state_r <= ST_RD;
        end
        ST_RD: begin
          unique case (ph_r)
            PH_C: ph_r <= PH_L;
            PH_L: ph_r <= PH_R;
            PH_R: ph_r <= PH_U;
            PH_U: ph_r <= PH_D;
            default: begin
              ph_r    <= PH_C;
              state_r <= ST_LAST;
            end
          endcase
        end
        ST_LAST: state_r <= ST_LAP;
        ST_LAP:  state_r <= ST_SUM;
        ST_SUM:  state_r <= ST_WR;
        ST_WR: begin
          // Advance to the next cell, rotate banks after the last one
          if (x_r == wm1) begin
            x_r <= '0;
            if (y_r == hm1) begin
              bank_sel_r <= !bank_sel_r;
              state_r    <= ST_DONE;
            end else begin
              y_r     <= y_r + 1'b1;
              state_r <= ST_RD;
            end
          end else begin
            x_r     <= x_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_CX: state_r <= ST_CY;
        ST_CY: begin
          cx_r    <= XW'(cm);
          inx_r   <= in_x;
          state_r <= ST_CC;
        end
        ST_CC: begin
          cy_r    <= YW'(cm);
          state_r <= (inx_r && in_y) ? ST_PA : ST_DONE;
          if (!(inx_r && in_y)) begin
            res_s_r <= wrg_pkg::STAT_OUTSIDE;
          end
        end
        ST_PA: state_r <= ST_PB;
        ST_PB: begin
          if (op_r == wrg_pkg::OP_READ) begin
            res_h_r <= rext[15:0];
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_data_r <= res_h_r;
            out_user_r <= res_s_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/wrg_ram.sv]
// Single-port height bank with registered read data.
`default_nettype none
module wrg_ram #(
  parameter int DEPTH = wrg_pkg::DEF_MAX_WIDTH * wrg_pkg::DEF_MAX_HEIGHT,
  parameter int DW    = wrg_pkg::DEF_HEIGHT_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DW-1:0]            wdata,
  output logic      [DW-1:0]            rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write on enable, always read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule
`default_nettype wire

[rtl/wrg_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none
module wrg_mul #(
  parameter int AW = 35,
  parameter int BW = 18
) (
  input  wire logic                      clk,
  input  wire logic signed [AW-1:0]      a,
  input  wire logic signed [BW-1:0]      b,
  output logic      signed [AW+BW-1:0]   p_r
);

  // Register the product for the next sequencer step
  always_ff @(posedge clk) begin
    p_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule
`default_nettype wire
